// File: hdl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants of the triangle rasteriser.
// ----------------------------------------------------------------------------
package trz_pkg;

    localparam int DEF_FRAME_WIDTH  = 64;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_GRAY = 3'd3;

    localparam logic signed [15:0] LIGHT_X_RST    = 16'sd0;
    localparam logic signed [15:0] LIGHT_Y_RST    = 16'sd11469;
    localparam logic signed [15:0] LIGHT_Z_RST    = -16'sd11469;
    localparam logic [7:0]         CLEAR_GRAY_RST = 8'd64;

    localparam logic signed [31:0] DEPTH_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DEPTH_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] NEAR_LIMIT = 32'sd655;
    localparam logic signed [35:0] LIGHT_LOW  = 36'sd1638;
    localparam logic signed [35:0] LIGHT_ONE  = 36'sd16384;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DRAW  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [1:0]          vertex_slot;
        logic signed [15:0]  vertex_x;
        logic signed [15:0]  vertex_y;
        logic signed [31:0]  vertex_z;
        logic signed [15:0]  normal_x;
        logic signed [15:0]  normal_y;
        logic signed [15:0]  normal_z;
        logic [11:0]         pixel_index;
    } request_t;

    typedef struct packed {
        logic [7:0]          pixel_gray;
        logic signed [31:0]  pixel_depth;
    } result_t;

    // work item passed from front to back
    typedef struct packed {
        op_t                 op;
        logic [1:0]          slot;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic signed [31:0]  z;
        logic signed [31:0]  light;
        logic [11:0]         index;
    } item_t;

endpackage

// File: hdl/triangle_raster_zbuffer_gouraud.sv
// ----------------------------------------------------------------------------
// triangle_raster_zbuffer_gouraud
// Edge function triangle rasteriser with depth buffer and gray shading.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset the
// frame is swept once to maximum depth and background gray, with busy
// held high; a clear request runs the same sweep without holding busy high.
// A load runs the light dot product in the front (one 16x16 multiply a
// cycle); a read passes through S_READ_ADDR and S_READ_OUT in the back
// before its result is registered. A draw runs its setup, then walks its
// clamped bounding box one pixel per cycle for uncovered pixels, while
// covered ones wait on the 17 step weight divider and the six multiplies
// of the single shared multiplier. Up to two requests wait in a queue
// between front and back. A result appears for one cycle with result_valid
// and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module triangle_raster_zbuffer_gouraud #(
    parameter int FRAME_WIDTH  = trz_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = trz_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  trz_pkg::request_t                   request,
    output logic                                result_valid,
    output trz_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trz_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [trz_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import trz_pkg::*;

    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg;
    logic [7:0]         clear_gray_reg;
    logic               push, pop, q_empty, q_full, clearing;
    item_t              push_item, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg    <= LIGHT_X_RST;
            light_y_reg    <= LIGHT_Y_RST;
            light_z_reg    <= LIGHT_Z_RST;
            clear_gray_reg <= CLEAR_GRAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LIGHT_X:    light_x_reg    <= $signed(cfg_data);
                CFG_LIGHT_Y:    light_y_reg    <= $signed(cfg_data);
                CFG_LIGHT_Z:    light_z_reg    <= $signed(cfg_data);
                CFG_CLEAR_GRAY: clear_gray_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    trz_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request), .busy(busy),
        .light_x(light_x_reg), .light_y(light_y_reg), .light_z(light_z_reg),
        .q_full(q_full), .clearing(clearing), .push(push), .push_item(push_item)
    );

    trz_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
        .pop(pop), .head(q_head), .empty(q_empty), .full(q_full)
    );

    trz_back #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .pop(pop),
        .clear_gray(clear_gray_reg), .clearing(clearing),
        .result_valid(result_valid), .result(result)
    );

endmodule

// File: hdl/trz_ram.sv
// ----------------------------------------------------------------------------
// trz_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module trz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/trz_queue.sv
// ----------------------------------------------------------------------------
// trz_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module trz_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  trz_pkg::item_t push_item,
    input  logic           pop,
    output trz_pkg::item_t head,
    output logic           empty,
    output logic           full
);
    import trz_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/trz_front.sv
// ----------------------------------------------------------------------------
// trz_front
// Accepts requests, drops loads to a bad slot, works out corner lighting.
// ----------------------------------------------------------------------------
module trz_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  trz_pkg::request_t     request,
    output logic                  busy,
    input  logic signed [15:0]    light_x,
    input  logic signed [15:0]    light_y,
    input  logic signed [15:0]    light_z,
    input  logic                  q_full,
    input  logic                  clearing,
    output logic                  push,
    output trz_pkg::item_t        push_item
);
    import trz_pkg::*;

    typedef enum logic {F_IDLE, F_DOT} fstate_t;

    fstate_t            state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    item_t              item_reg, item_next;
    logic signed [15:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [33:0] acc_reg, acc_next;

    logic               accept;
    logic signed [15:0] mul_a, mul_b;
    logic signed [33:0] dot;

    assign busy   = (state_reg != F_IDLE) || q_full || clearing;
    assign accept = start && !busy;
    assign dot    = acc_reg + 34'(prod_reg);

    always_comb
    begin
        mul_a = nx_reg;
        mul_b = light_x;
        case (cnt_reg)
            2'd1:
            begin
                mul_a = ny_reg;
                mul_b = light_y;
            end
            2'd2:
            begin
                mul_a = nz_reg;
                mul_b = light_z;
            end
            default:
            begin
                mul_a = nx_reg;
                mul_b = light_x;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        nz_next    = nz_reg;
        prod_next  = mul_a * mul_b;
        acc_next   = acc_reg;
        push       = 1'b0;
        push_item  = item_reg;

        case (state_reg)
            F_IDLE:
            begin
                push_item.op    = op_t'(request.command);
                push_item.slot  = request.vertex_slot;
                push_item.x     = request.vertex_x;
                push_item.y     = request.vertex_y;
                push_item.z     = request.vertex_z;
                push_item.light = '0;
                push_item.index = request.pixel_index;
                if (accept)
                begin
                    if (op_t'(request.command) == OP_LOAD)
                    begin
                        if (request.vertex_slot != 2'd3)
                        begin
                            item_next  = push_item;
                            nx_next    = request.normal_x;
                            ny_next    = request.normal_y;
                            nz_next    = request.normal_z;
                            cnt_next   = '0;
                            acc_next   = '0;
                            state_next = F_DOT;
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
            end
            F_DOT:
            begin
                if (cnt_reg != 2'd0)
                begin
                    acc_next = dot;
                end
                if (cnt_reg == 2'd3)
                begin
                    push            = 1'b1;
                    push_item.light = 32'(dot >>> 14);
                    state_next      = F_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        nz_reg   <= nz_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

// File: hdl/trz_back.sv
// ----------------------------------------------------------------------------
// trz_back
// Executes requests: frame clear, corner load, triangle walk, pixel read.
// ----------------------------------------------------------------------------
module trz_back #(
    parameter int FRAME_WIDTH  = trz_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = trz_pkg::DEF_FRAME_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  trz_pkg::item_t    q_head,
    output logic              pop,
    input  logic [7:0]        clear_gray,
    output logic              clearing,
    output logic              result_valid,
    output trz_pkg::result_t  result
);
    import trz_pkg::*;

    localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int XW     = $clog2(FRAME_WIDTH + 1);
    localparam int YW     = $clog2(FRAME_HEIGHT + 1);
    localparam logic signed [13:0] FW_S = 14'(FRAME_WIDTH);
    localparam logic signed [13:0] FH_S = 14'(FRAME_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_READ_ADDR, S_READ_OUT, S_SETUP,
        S_PX_TEST, S_PX_DIV, S_PX_MUL, S_PX_WRITE
    } state_t;

    function automatic logic signed [17:0] sub18(input logic signed [17:0] a,
                                                 input logic signed [17:0] b);
        sub18 = a - b;
    endfunction

    function automatic logic [39:0] mag40(input logic signed [39:0] v);
        mag40 = v[39] ? 40'(-v) : 40'(v);
    endfunction

    function automatic logic signed [39:0] x16(input logic signed [17:0] d);
        x16 = 40'(d) <<< 4;
    endfunction

    state_t             state_reg, state_next;
    logic               init_reg, init_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [11:0]        idx_reg, idx_next;
    logic signed [15:0] cx_reg [3], cx_next [3];
    logic signed [15:0] cy_reg [3], cy_next [3];
    logic signed [31:0] cz_reg [3], cz_next [3];
    logic signed [31:0] cl_reg [3], cl_next [3];
    logic [XW-1:0]      lo_x_reg, lo_x_next, hi_x_reg, hi_x_next, x_reg, x_next;
    logic [YW-1:0]      lo_y_reg, lo_y_next, hi_y_reg, hi_y_next, y_reg, y_next;
    logic [AW-1:0]      row_reg, row_next, addr_reg, addr_next;
    logic signed [39:0] w_reg [3], w_next [3];
    logic signed [39:0] wrow_reg [3], wrow_next [3];
    logic signed [39:0] area_reg, area_next;
    logic [40:0]        r1_reg, r1_next, r2_reg, r2_next;
    logic [16:0]        q1_reg, q1_next, q2_reg, q2_next;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [51:0] accd_reg, accd_next, accl_reg, accl_next;
    logic               rv_reg, rv_next;
    result_t            res_reg, res_next;

    // corner geometry
    logic signed [17:0] ex [3], ey [3];
    logic signed [39:0] dx [3], dy [3];
    logic signed [15:0] min_x, max_x, min_y, max_y;
    logic signed [13:0] blo_x, bhi_x, blo_y, bhi_y;
    logic               near, box_empty;
    logic signed [17:0] px0, py0;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [17:0] l0, l1, l2;
    logic [39:0]        dvs;
    logic [40:0]        t1, t2;
    logic signed [39:0] p40;
    logic signed [35:0] d36, li36;
    logic signed [31:0] dsat;
    logic [14:0]        li;
    logic [22:0]        li255;
    logic               covered, adv;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [31:0]        ram_wdepth, depth_rd;
    logic [7:0]         ram_wgray, gray_rd;

    trz_ram #(.WIDTH(32), .DEPTH(PIXELS)) u_depth (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdepth),
        .raddr(ram_raddr), .rdata(depth_rd)
    );

    trz_ram #(.WIDTH(8), .DEPTH(PIXELS)) u_gray (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wgray),
        .raddr(ram_raddr), .rdata(gray_rd)
    );

    assign clearing     = init_reg;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // edge k runs from corner A to corner B: (1,2), (2,0), (0,1)
    always_comb
    begin
        ex[0] = sub18(18'(cx_reg[2]), 18'(cx_reg[1]));
        ey[0] = sub18(18'(cy_reg[2]), 18'(cy_reg[1]));
        ex[1] = sub18(18'(cx_reg[0]), 18'(cx_reg[2]));
        ey[1] = sub18(18'(cy_reg[0]), 18'(cy_reg[2]));
        ex[2] = sub18(18'(cx_reg[1]), 18'(cx_reg[0]));
        ey[2] = sub18(18'(cy_reg[1]), 18'(cy_reg[0]));
        for (int k = 0; k < 3; k++)
        begin
            dx[k] = -x16(ey[k]);
            dy[k] = x16(ex[k]);
        end
    end

    always_comb
    begin
        min_x = cx_reg[0];
        max_x = cx_reg[0];
        min_y = cy_reg[0];
        max_y = cy_reg[0];
        for (int k = 1; k < 3; k++)
        begin
            if (cx_reg[k] < min_x) min_x = cx_reg[k];
            if (cx_reg[k] > max_x) max_x = cx_reg[k];
            if (cy_reg[k] < min_y) min_y = cy_reg[k];
            if (cy_reg[k] > max_y) max_y = cy_reg[k];
        end
        blo_x = 14'(min_x >>> 4);
        blo_y = 14'(min_y >>> 4);
        bhi_x = 14'((17'(max_x) + 17'sd15) >>> 4);
        bhi_y = 14'((17'(max_y) + 17'sd15) >>> 4);
        if (blo_x < 14'sd0) blo_x = '0;
        if (blo_y < 14'sd0) blo_y = '0;
        if (bhi_x > FW_S) bhi_x = FW_S;
        if (bhi_y > FH_S) bhi_y = FH_S;
        box_empty = (blo_x >= bhi_x) || (blo_y >= bhi_y);
        near = (cz_reg[0] <= NEAR_LIMIT) || (cz_reg[1] <= NEAR_LIMIT) ||
               (cz_reg[2] <= NEAR_LIMIT);
    end

    assign px0 = $signed(18'({lo_x_reg, 4'b1000}));
    assign py0 = $signed(18'({lo_y_reg, 4'b1000}));
    assign l1  = $signed({1'b0, q1_reg});
    assign l2  = $signed({1'b0, q2_reg});
    assign l0  = 18'sd65536 - l1 - l2;
    assign dvs = mag40(area_reg);
    assign p40 = 40'(prod_reg);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SETUP)
        begin
            case (cnt_reg)
                5'd0: begin mul_a = ex[0]; mul_b = 32'(sub18(py0, 18'(cy_reg[1]))); end
                5'd1: begin mul_a = ey[0]; mul_b = 32'(sub18(px0, 18'(cx_reg[1]))); end
                5'd2: begin mul_a = ex[1]; mul_b = 32'(sub18(py0, 18'(cy_reg[2]))); end
                5'd3: begin mul_a = ey[1]; mul_b = 32'(sub18(px0, 18'(cx_reg[2]))); end
                5'd4: begin mul_a = ex[2]; mul_b = 32'(sub18(py0, 18'(cy_reg[0]))); end
                5'd5: begin mul_a = ey[2]; mul_b = 32'(sub18(px0, 18'(cx_reg[0]))); end
                5'd6: begin mul_a = ex[2]; mul_b = 32'(-ey[1]); end
                5'd7: begin mul_a = ey[2]; mul_b = 32'(-ex[1]); end
                5'd8: begin mul_a = $signed(18'(lo_y_reg)); mul_b = 32'(FRAME_WIDTH); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_PX_MUL)
        begin
            case (cnt_reg)
                5'd0: begin mul_a = l0; mul_b = cz_reg[0]; end
                5'd1: begin mul_a = l1; mul_b = cz_reg[1]; end
                5'd2: begin mul_a = l2; mul_b = cz_reg[2]; end
                5'd3: begin mul_a = l0; mul_b = cl_reg[0]; end
                5'd4: begin mul_a = l1; mul_b = cl_reg[1]; end
                5'd5: begin mul_a = l2; mul_b = cl_reg[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        covered = ((w_reg[0] >= 0) && (w_reg[1] >= 0) && (w_reg[2] >= 0)) ||
                  ((w_reg[0] <= 0) && (w_reg[1] <= 0) && (w_reg[2] <= 0));
        t1 = (cnt_reg == '0) ? r1_reg : {r1_reg[39:0], 1'b0};
        t2 = (cnt_reg == '0) ? r2_reg : {r2_reg[39:0], 1'b0};
        d36 = 36'(accd_reg >>> 16);
        if (d36 > 36'(DEPTH_MAX))
            dsat = DEPTH_MAX;
        else if (d36 < 36'(DEPTH_MIN))
            dsat = DEPTH_MIN;
        else
            dsat = 32'(d36);
        li36 = 36'(accl_reg >>> 16);
        if (li36 < LIGHT_LOW)
            li36 = LIGHT_LOW;
        if (li36 > LIGHT_ONE)
            li36 = LIGHT_ONE;
        li    = 15'(li36);
        li255 = {li, 8'd0} - 23'(li);
    end

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        clr_cnt_next = clr_cnt_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        cl_next      = cl_reg;
        lo_x_next    = lo_x_reg;
        hi_x_next    = hi_x_reg;
        lo_y_next    = lo_y_reg;
        hi_y_next    = hi_y_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        row_next     = row_reg;
        addr_next    = addr_reg;
        w_next       = w_reg;
        wrow_next    = wrow_reg;
        area_next    = area_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        q1_next      = q1_reg;
        q2_next      = q2_reg;
        prod_next    = mul_a * mul_b;
        accd_next    = accd_reg;
        accl_next    = accl_reg;
        rv_next      = 1'b0;
        res_next     = res_reg;
        pop          = 1'b0;
        adv          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdepth   = dsat;
        ram_wgray    = li255[21:14];
        ram_raddr    = (state_reg == S_READ_ADDR) ? AW'(idx_reg) : addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (q_head.op)
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_LOAD:
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (q_head.slot == 2'(k))
                                begin
                                    cx_next[k] = q_head.x;
                                    cy_next[k] = q_head.y;
                                    cz_next[k] = q_head.z;
                                    cl_next[k] = q_head.light;
                                end
                            end
                        end
                        OP_DRAW:
                        begin
                            if (!near && !box_empty)
                            begin
                                lo_x_next  = XW'(blo_x);
                                hi_x_next  = XW'(bhi_x);
                                lo_y_next  = YW'(blo_y);
                                hi_y_next  = YW'(bhi_y);
                                x_next     = XW'(blo_x);
                                y_next     = YW'(blo_y);
                                wrow_next  = '{default: '0};
                                area_next  = '0;
                                cnt_next   = '0;
                                state_next = S_SETUP;
                            end
                        end
                        default:
                        begin
                            idx_next   = q_head.index;
                            state_next = S_READ_ADDR;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdepth   = DEPTH_MAX;
                ram_wgray    = clear_gray;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(PIXELS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_READ_ADDR:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                rv_next = 1'b1;
                if (32'(idx_reg) < 32'(PIXELS))
                begin
                    res_next.pixel_gray  = gray_rd;
                    res_next.pixel_depth = $signed(depth_rd);
                end
                else
                begin
                    res_next.pixel_gray  = '0;
                    res_next.pixel_depth = '0;
                end
                state_next = S_IDLE;
            end
            S_SETUP:
            begin
                // product issued last cycle lands in its accumulator now
                case (cnt_reg)
                    5'd1: wrow_next[0] = wrow_reg[0] + p40;
                    5'd2: wrow_next[0] = wrow_reg[0] - p40;
                    5'd3: wrow_next[1] = wrow_reg[1] + p40;
                    5'd4: wrow_next[1] = wrow_reg[1] - p40;
                    5'd5: wrow_next[2] = wrow_reg[2] + p40;
                    5'd6: wrow_next[2] = wrow_reg[2] - p40;
                    5'd7: area_next    = area_reg + p40;
                    5'd8: area_next    = area_reg - p40;
                    5'd9:
                    begin
                        row_next  = AW'(prod_reg);
                        addr_next = AW'(prod_reg) + AW'(lo_x_reg);
                    end
                    default: ;
                endcase
                if (cnt_reg == 5'd9)
                begin
                    w_next     = wrow_reg;
                    state_next = (area_reg == '0) ? S_IDLE : S_PX_TEST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PX_TEST:
            begin
                if (covered)
                begin
                    r1_next    = {1'b0, mag40(w_reg[1])};
                    r2_next    = {1'b0, mag40(w_reg[2])};
                    q1_next    = '0;
                    q2_next    = '0;
                    cnt_next   = '0;
                    state_next = S_PX_DIV;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_PX_DIV:
            begin
                if (t1 >= {1'b0, dvs})
                begin
                    r1_next = t1 - {1'b0, dvs};
                    q1_next = {q1_reg[15:0], 1'b1};
                end
                else
                begin
                    r1_next = t1;
                    q1_next = {q1_reg[15:0], 1'b0};
                end
                if (t2 >= {1'b0, dvs})
                begin
                    r2_next = t2 - {1'b0, dvs};
                    q2_next = {q2_reg[15:0], 1'b1};
                end
                else
                begin
                    r2_next = t2;
                    q2_next = {q2_reg[15:0], 1'b0};
                end
                if (cnt_reg == 5'd16)
                begin
                    cnt_next   = '0;
                    accd_next  = '0;
                    accl_next  = '0;
                    state_next = S_PX_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PX_MUL:
            begin
                if (cnt_reg >= 5'd1 && cnt_reg <= 5'd3)
                    accd_next = accd_reg + 52'(prod_reg);
                else if (cnt_reg >= 5'd4)
                    accl_next = accl_reg + 52'(prod_reg);
                if (cnt_reg == 5'd6)
                    state_next = S_PX_WRITE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PX_WRITE:
            begin
                ram_we = (dsat < $signed(depth_rd));
                adv    = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next pixel of the box
        if (adv)
        begin
            state_next = S_PX_TEST;
            if (XW'(x_reg + 1'b1) < hi_x_reg)
            begin
                x_next    = x_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
                for (int k = 0; k < 3; k++)
                    w_next[k] = w_reg[k] + dx[k];
            end
            else if (YW'(y_reg + 1'b1) < hi_y_reg)
            begin
                y_next    = y_reg + 1'b1;
                x_next    = lo_x_reg;
                row_next  = row_reg + AW'(FRAME_WIDTH);
                addr_next = row_reg + AW'(FRAME_WIDTH) + AW'(lo_x_reg);
                for (int k = 0; k < 3; k++)
                begin
                    wrow_next[k] = wrow_reg[k] + dy[k];
                    w_next[k]    = wrow_reg[k] + dy[k];
                end
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            init_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            res_reg     <= '0;
            for (int k = 0; k < 3; k++)
            begin
                cx_reg[k] <= '0;
                cy_reg[k] <= '0;
                cz_reg[k] <= '0;
                cl_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_cnt_reg <= clr_cnt_next;
            cnt_reg     <= cnt_next;
            rv_reg      <= rv_next;
            res_reg     <= res_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            cz_reg      <= cz_next;
            cl_reg      <= cl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lo_x_reg <= lo_x_next;
        hi_x_reg <= hi_x_next;
        lo_y_reg <= lo_y_next;
        hi_y_reg <= hi_y_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        row_reg  <= row_next;
        addr_reg <= addr_next;
        w_reg    <= w_next;
        wrow_reg <= wrow_next;
        area_reg <= area_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        q1_reg   <= q1_next;
        q2_reg   <= q2_next;
        prod_reg <= prod_next;
        accd_reg <= accd_next;
        accl_reg <= accl_next;
    end

endmodule
